// ===== rtl/core/gtp_pkg.sv =====
// gtp_pkg: shared types, widths and codes of the gray to palette false color block
// no dependencies; imported by every module of the block but gtp_ram
package gtp_pkg;

   // default palette size
   localparam int PALETTE_DEPTH_DEF = 256;

   // field widths
   localparam int CH_W    = 8;
   localparam int COLOR_W = 3 * CH_W;
   localparam int SUM_W   = 10;
   localparam int LEVEL_W = 8;

   // mean of three channels: sum * 683 >> 11 equals sum / 3 for sums up to 765
   localparam int RECIP3_W     = 10;
   localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
   localparam int RECIP3_SHIFT = 11;

   // scaling divider: numerator 2*num*top + d - 1, divisor 2*d, quotient <= top
   localparam int NUM_W  = 17;
   localparam int DEN_W  = 9;
   localparam int QUOT_W = 8;

   // item kinds
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_TOP = 2'd2;

   // register reset values
   localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST   = 8'd0;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST   = 8'd255;
   localparam logic [LEVEL_W-1:0] PALETTE_TOP_RST = 8'd255;

   // configuration seen by the datapath
   typedef struct packed {
      logic [LEVEL_W-1:0] min_level;
      logic [LEVEL_W-1:0] max_level;
      logic [LEVEL_W-1:0] palette_top;
   } gtp_cfg_type;

   // what travels with an item down the pipeline
   typedef struct packed {
      logic               func;
      logic [7:0]         entry_index;
      logic [COLOR_W-1:0] entry_color;
      logic               zero_span;
   } gtp_side_type;

endpackage

// ===== rtl/core/gtp_ram.sv =====
// gtp_ram: generic single write port, single read port ram with registered read
// no dependencies
module gtp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/gtp_prep.sv =====
// gtp_prep: three stages that form the gray mean, clamp it and build the
// numerator and divisor of the index scaling; uses gtp_pkg
module gtp_prep (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  gtp_pkg::gtp_cfg_type               cfg,
   input  logic                               in_valid,
   input  logic                               in_func,
   input  logic [7:0]                         in_entry_index,
   input  logic [gtp_pkg::COLOR_W-1:0]        in_entry_color,
   input  logic [gtp_pkg::CH_W-1:0]           in_ch0,
   input  logic [gtp_pkg::CH_W-1:0]           in_ch1,
   input  logic [gtp_pkg::CH_W-1:0]           in_ch2,
   output logic                               out_valid,
   output gtp_pkg::gtp_side_type              out_side,
   output logic [gtp_pkg::NUM_W-1:0]          out_num,
   output logic [gtp_pkg::DEN_W-1:0]          out_den
);
   import gtp_pkg::*;

   logic                 v1_ff, v2_ff, v3_ff;
   gtp_side_type         side1_ff, side2_ff, side3_ff;
   gtp_side_type         side1_in, side3_in;
   logic [SUM_W-1:0]     sum1_ff, sum1_in;
   logic [LEVEL_W-1:0]   gray2_ff, gray2_in;
   logic [SUM_W+RECIP3_W-1:0] prod2;
   logic [NUM_W-1:0]     num3_ff, num3_in;
   logic [DEN_W-1:0]     den3_ff, den3_in;
   logic [LEVEL_W-1:0]   lvl_hi, lvl, lvl_num, span;
   logic [2*LEVEL_W-1:0] prod3;
   logic                 zero_span;

   // stage 1: channel sum
   always_comb begin
      side1_in.func        = in_func;
      side1_in.entry_index = in_entry_index;
      side1_in.entry_color = in_entry_color;
      side1_in.zero_span   = 1'b0;
      sum1_in = SUM_W'(in_ch0) + SUM_W'(in_ch1) + SUM_W'(in_ch2);
   end

   // stage 2: divide by three through the reciprocal
   assign prod2    = (SUM_W+RECIP3_W)'(sum1_ff) * (SUM_W+RECIP3_W)'(RECIP3);
   assign gray2_in = prod2[RECIP3_SHIFT +: LEVEL_W];

   // stage 3: clamp to max then min, numerator 2*num*top + d - 1, divisor 2*d
   always_comb begin
      lvl_hi    = (gray2_ff > cfg.max_level) ? cfg.max_level : gray2_ff;
      lvl       = (lvl_hi < cfg.min_level) ? cfg.min_level : lvl_hi;
      zero_span = (cfg.max_level <= cfg.min_level);
      lvl_num   = lvl - cfg.min_level;
      span      = cfg.max_level - cfg.min_level;
      prod3     = (2*LEVEL_W)'(lvl_num) * (2*LEVEL_W)'(cfg.palette_top);
      num3_in   = {prod3, 1'b0} + NUM_W'(span) - NUM_W'(1);
      den3_in   = {span, 1'b0};
      side3_in  = side2_ff;
      side3_in.zero_span = zero_span;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         sum1_ff  <= sum1_in;
         side2_ff <= side1_ff;
         gray2_ff <= gray2_in;
         side3_ff <= side3_in;
         num3_ff  <= num3_in;
         den3_ff  <= den3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = side3_ff;
   assign out_num   = num3_ff;
   assign out_den   = den3_ff;

endmodule

// ===== rtl/core/gtp_div.sv =====
// gtp_div: pipelined restoring divider, one quotient bit per stage
// uses gtp_pkg; the quotient is known to fit in QUOT_W bits
module gtp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  gtp_pkg::gtp_side_type         in_side,
   input  logic [gtp_pkg::NUM_W-1:0]     in_num,
   input  logic [gtp_pkg::DEN_W-1:0]     in_den,
   output logic                          out_valid,
   output gtp_pkg::gtp_side_type         out_side,
   output logic [gtp_pkg::QUOT_W-1:0]    out_quot
);
   import gtp_pkg::*;

   logic               valid_ff [QUOT_W];
   gtp_side_type       side_ff  [QUOT_W];
   logic [NUM_W-1:0]   rem_ff   [QUOT_W];
   logic [DEN_W-1:0]   den_ff   [QUOT_W];
   logic [QUOT_W-1:0]  quot_ff  [QUOT_W];

   for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - s;

      logic               valid_src;
      gtp_side_type       side_src;
      logic [NUM_W-1:0]   rem_src, trial, rem_in;
      logic [DEN_W-1:0]   den_src;
      logic [QUOT_W-1:0]  quot_src, quot_in;
      logic               take;

      // stage operands
      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign side_src  = in_side;
         assign rem_src   = in_num;
         assign den_src   = in_den;
         assign quot_src  = '0;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign side_src  = side_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign quot_src  = quot_ff[s-1];
      end

      // compare against the shifted divisor and subtract
      always_comb begin
         trial   = NUM_W'(den_src) << BIT;
         take    = (rem_src >= trial);
         rem_in  = take ? (rem_src - trial) : rem_src;
         quot_in = quot_src | (QUOT_W'(take) << BIT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= side_src;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            quot_ff[s] <= quot_in;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];

endmodule

// ===== rtl/core/gray_to_palette_false_color_top.sv =====
// gray_to_palette_false_color_top: false color mapping of pixels through a palette ram
// uses gtp_pkg, gtp_prep, gtp_div and gtp_ram
//
// Usage
//   req channel: one item per accepted cycle. req_func selects the kind: a palette
//   write stores req_entry_color at req_entry_index and gives no result; a pixel
//   item maps the mean of req_pix_ch0..2 through the palette and gives one rsp item
//   with red, green and blue on rsp_out_ch0..2.
//   csr port: csr_write_en, csr_index, csr_wdata set min_level, max_level and
//   palette_top; write only while the block is idle.
//   Throughput: one item per cycle while req_stall is low, set by the fully pipelined
//   datapath (three preparation stages, eight divider stages, one palette ram read).
//   A pixel item runs through these stages and then the output register to rsp.
//   Items leave in the order they arrive; a palette write takes effect for every
//   pixel accepted after it, since writes and reads meet the ram in the same stage.
//   Stall: an output register plus a skid register absorb one stalled result; the
//   pipeline keeps taking items until the skid register fills, then req_stall rises.
//   Reset: clears all stage valids, the output and skid registers and loads the
//   register defaults; the palette holds no defined contents until written.
module gray_to_palette_false_color_top #(
   parameter int PALETTE_DEPTH = gtp_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [7:0]                       req_entry_index,
   input  logic [gtp_pkg::COLOR_W-1:0]      req_entry_color,
   input  logic [gtp_pkg::CH_W-1:0]         req_pix_ch0,
   input  logic [gtp_pkg::CH_W-1:0]         req_pix_ch1,
   input  logic [gtp_pkg::CH_W-1:0]         req_pix_ch2,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gtp_pkg::CH_W-1:0]         rsp_out_ch0,
   output logic [gtp_pkg::CH_W-1:0]         rsp_out_ch1,
   output logic [gtp_pkg::CH_W-1:0]         rsp_out_ch2,
   // configuration
   input  logic                             csr_write_en,
   input  logic [gtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtp_pkg::LEVEL_W-1:0]      csr_wdata
);
   import gtp_pkg::*;

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_DEPTH - 1);

   gtp_cfg_type         cfg_ff;
   logic                en;

   logic                prep_valid;
   gtp_side_type        prep_side;
   logic [NUM_W-1:0]    prep_num;
   logic [DEN_W-1:0]    prep_den;

   logic                div_valid;
   gtp_side_type        div_side;
   logic [QUOT_W-1:0]   div_quot;

   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [COLOR_W-1:0]  ram_rdata;
   logic                rd_valid_ff;

   logic                out_valid_ff, skid_full_ff;
   logic [COLOR_W-1:0]  out_data_ff, skid_data_ff;

   // pipeline advances unless the skid register holds a result
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_level   <= MIN_LEVEL_RST;
         cfg_ff.max_level   <= MAX_LEVEL_RST;
         cfg_ff.palette_top <= PALETTE_TOP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_LEVEL:   cfg_ff.min_level   <= csr_wdata;
            CSR_MAX_LEVEL:   cfg_ff.max_level   <= csr_wdata;
            CSR_PALETTE_TOP: cfg_ff.palette_top <= csr_wdata;
            default: ;
         endcase
      end
   end

   // mean, clamp and scaling operands
   gtp_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .cfg            (cfg_ff),
      .in_valid       (req_valid),
      .in_func        (req_func),
      .in_entry_index (req_entry_index),
      .in_entry_color (req_entry_color),
      .in_ch0         (req_pix_ch0),
      .in_ch1         (req_pix_ch1),
      .in_ch2         (req_pix_ch2),
      .out_valid      (prep_valid),
      .out_side       (prep_side),
      .out_num        (prep_num),
      .out_den        (prep_den)
   );

   // palette index by pipelined division
   gtp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_side   (prep_side),
      .in_num    (prep_num),
      .in_den    (prep_den),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quot  (div_quot)
   );

   // palette access: writes in range, reads with zero span and saturation
   always_comb begin
      ram_we    = en && div_valid && (div_side.func == FUNC_WRITE) &&
                  (32'(div_side.entry_index) < PALETTE_DEPTH);
      ram_waddr = ADDR_W'(div_side.entry_index);
      ram_re    = en && div_valid && (div_side.func == FUNC_PIXEL);
      if (div_side.zero_span) begin
         ram_raddr = '0;
      end else if (32'(div_quot) >= PALETTE_DEPTH) begin
         ram_raddr = LAST_ADDR;
      end else begin
         ram_raddr = ADDR_W'(div_quot);
      end
   end

   gtp_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (div_side.entry_color),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // read stage valid, lines up with the registered ram data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (en) begin
         rd_valid_ff <= ram_re;
      end
   end

   // output register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (!rsp_stall) begin
            skid_full_ff <= 1'b0;
         end
      end else if (out_valid_ff && rsp_stall) begin
         if (rd_valid_ff) begin
            skid_full_ff <= 1'b1;
         end
      end else begin
         out_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (!rsp_stall) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (out_valid_ff && rsp_stall) begin
         if (rd_valid_ff) begin
            skid_data_ff <= ram_rdata;
         end
      end else begin
         out_data_ff <= ram_rdata;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_out_ch0 = out_data_ff[2*CH_W +: CH_W];
   assign rsp_out_ch1 = out_data_ff[CH_W +: CH_W];
   assign rsp_out_ch2 = out_data_ff[0 +: CH_W];

endmodule

// ===== rtl/core/gtp_checker.sv =====
// gtp_checker: port level assertions for gray_to_palette_false_color_top
// uses gtp_pkg; bound to the top level at the end of this file
module gtp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [gtp_pkg::CH_W-1:0]  rsp_out_ch0,
   input logic [gtp_pkg::CH_W-1:0]  rsp_out_ch1,
   input logic [gtp_pkg::CH_W-1:0]  rsp_out_ch2
);
   import gtp_pkg::*;

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output or skid register not cleared by reset");

   // input stalls only while a result sits in the skid register behind a valid output
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result on the output");

   // skid register fills only after the output was held by the receiver
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall raised without an output stall");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_ch0) && $stable(rsp_out_ch1) &&
          $stable(rsp_out_ch2)))
      else $error("stalled result changed");

endmodule

bind gray_to_palette_false_color_top gtp_checker u_checker (.*);
